[src/dslpg_pkg.sv]
package dslpg_pkg;

    localparam int MaxPixels = 524288;
    localparam int IdxW = $clog2(MaxPixels);
    localparam int CntW = 10;
    localparam int AddrW = 5;
    localparam logic [CntW-1:0] CounterMax = 10'd1023;

    localparam logic [AddrW-1:0] RegWidth = 5'd0;
    localparam logic [AddrW-1:0] RegHeight = 5'd4;
    localparam logic [AddrW-1:0] RegCenterX = 5'd8;
    localparam logic [AddrW-1:0] RegCenterY = 5'd12;
    localparam logic [AddrW-1:0] RegInvFx = 5'd16;
    localparam logic [AddrW-1:0] RegInvFy = 5'd20;
    localparam logic [AddrW-1:0] RegMargin = 5'd24;
    localparam logic [AddrW-1:0] RegTimeout = 5'd28;

    typedef struct packed {
        logic [15:0] depth;
        logic [31:0] stamp;
    } shadow_key_t;

    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] color;
    } shadow_pay_t;

    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic [15:0] z;
        logic [23:0] color;
        logic        from_shadow;
        logic        last;
    } point_t;

endpackage

[src/dslpg_project.sv]
module dslpg_project (
    input  logic        aclk,
    input  logic        en,
    input  logic [9:0]  pos,
    input  logic [15:0] center,
    input  logic [23:0] inv,
    input  logic [15:0] depth,
    output logic [23:0] coord
);
    // Three stages: d*inv, then *depth, then round and saturate.
    logic signed [15:0] pos16;
    logic signed [16:0] diff;
    logic               neg_reg, neg2_reg;
    logic [16:0]        mag;
    logic [40:0]        prod1_reg;
    logic [15:0]        depth_reg;
    logic [56:0]        prod2_reg;
    logic [33:0]        rnd;
    logic [23:0]        coord_next;

    assign pos16 = signed'({2'b00, pos, 4'b0000});
    assign diff = 17'(pos16) - 17'(signed'(center));
    assign mag = diff[16] ? 17'(-diff) : diff;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod1_reg <= 41'(mag) * 41'(inv);
            neg_reg <= diff[16];
            depth_reg <= depth;
            prod2_reg <= 57'(prod1_reg) * 57'(depth_reg);
            neg2_reg <= neg_reg;
            coord <= coord_next;
        end
    end

    always_comb begin
        rnd = 34'((prod2_reg + 57'(1 << 23)) >> 24);
        if (neg2_reg) begin
            coord_next = (rnd > 34'd8388608) ? 24'h800000 : 24'(-rnd);
        end else begin
            coord_next = (rnd > 34'd8388607) ? 24'h7FFFFF : rnd[23:0];
        end
    end
endmodule

[src/depth_shadow_layer_point_gen.sv]
// Pipeline: an accepted item moves through stages 1 to 4; three stages compute the projection
// while the shadow entry is read, and the fourth updates the entry and loads the output buffer,
// which presents the first point of a pixel on m_tdata. A shadow point follows once it is taken.
// Throughput: one pixel per cycle; a pixel with two points needs an output beat per point, so the
// input stalls whenever the two-entry output buffer cannot take all points of the pixel.
// Reset: control and configuration registers return to reset values; after aresetn rises the
// shadow key memory is cleared one entry per cycle, 524288 entries, while no item is accepted.
module depth_shadow_layer_point_gen (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // depth_mm, pixel_color, has_color, now_tick
    input  logic        s_tuser,  // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,  // point_x, point_y, point_z, point_color
    output logic        m_tuser,  // from_shadow
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dslpg_pkg::*;

    logic [10:0] width_reg, height_reg;
    logic [15:0] cx_reg, cy_reg, margin_reg;
    logic [23:0] ifx_reg, ify_reg;
    logic [31:0] timeout_reg;

    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= 11'd640; height_reg <= 11'd480;
            cx_reg <= 16'd5120; cy_reg <= 16'd3840;
            ifx_reg <= 24'd33554; ify_reg <= 24'd33554;
            margin_reg <= 16'd100; timeout_reg <= 32'd30000;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                RegWidth:   width_reg <= pwdata[10:0];
                RegHeight:  height_reg <= pwdata[10:0];
                RegCenterX: cx_reg <= pwdata[15:0];
                RegCenterY: cy_reg <= pwdata[15:0];
                RegInvFx:   ifx_reg <= pwdata[23:0];
                RegInvFy:   ify_reg <= pwdata[23:0];
                RegMargin:  margin_reg <= pwdata[15:0];
                RegTimeout: timeout_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            RegWidth:   prdata = 32'(width_reg);
            RegHeight:  prdata = 32'(height_reg);
            RegCenterX: prdata = 32'(cx_reg);
            RegCenterY: prdata = 32'(cy_reg);
            RegInvFx:   prdata = 32'(ifx_reg);
            RegInvFy:   prdata = 32'(ify_reg);
            RegMargin:  prdata = 32'(margin_reg);
            RegTimeout: prdata = timeout_reg;
            default:    prdata = '0;
        endcase
    end

    // Memories.
    shadow_key_t key_mem [MaxPixels];
    shadow_pay_t pay_mem [MaxPixels];
    shadow_key_t key_rd_reg;
    shadow_pay_t pay_rd_reg;

    // Clearing sweep.
    logic            clr_reg;
    logic [IdxW-1:0] clr_cnt_reg;

    // Pipeline control. Stages 1-3 project the point, stage 3 reads the store, stage 4 decides.
    logic            adv, s_take, out_take;
    logic            v1_reg, v2_reg, v3_reg, v4_reg;
    logic [CntW-1:0] col_reg, row_reg, col1_reg, row1_reg;
    logic [CntW-1:0] col_cur, row_cur, col_nx, row_nx;
    logic [20:0]     idx_full;
    logic [IdxW-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic            has1_reg, has2_reg, has3_reg, has4_reg;
    logic [15:0]     dep1_reg, dep2_reg, dep3_reg, dep4_reg;
    logic [23:0]     pc1_reg, pc2_reg, pc3_reg, pc4_reg;
    logic [31:0]     now1_reg, now2_reg, now3_reg, now4_reg;
    logic [23:0]     px, py;

    always_comb begin
        col_cur = s_tuser ? '0 : col_reg;
        row_cur = s_tuser ? '0 : row_reg;
        idx_full = 21'(row_cur) * 21'(width_reg) + 21'(col_cur);
        if ((11'(col_cur) + 11'd1 >= width_reg) || col_cur >= CounterMax) begin
            col_nx = '0;
            if ((11'(row_cur) + 11'd1 >= height_reg) || row_cur >= CounterMax) begin
                row_nx = '0;
            end else begin
                row_nx = row_cur + 1'b1;
            end
        end else begin
            col_nx = col_cur + 1'b1;
            row_nx = row_cur;
        end
    end

    dslpg_project u_px (.aclk(aclk), .en(adv), .pos(col1_reg), .center(cx_reg),
        .inv(ifx_reg), .depth(dep1_reg), .coord(px));
    dslpg_project u_py (.aclk(aclk), .en(adv), .pos(row1_reg), .center(cy_reg),
        .inv(ify_reg), .depth(dep1_reg), .coord(py));

    // Stage-4 decision. The entry written as stage 4 leaves is forwarded to the next pixel
    // when it reads the same entry at that edge.
    logic            fwd_reg;
    shadow_key_t     fwd_key_reg;
    shadow_pay_t     fwd_pay_reg;
    shadow_key_t     key_eff, wr_key;
    shadow_pay_t     pay_eff, wr_pay;
    logic [15:0]     sd;
    logic            expired, show, pix_ok, emit_pix, emit_sh, wr_en;
    logic [1:0]      n4, room, ocnt_reg;

    always_comb begin
        key_eff = fwd_reg ? fwd_key_reg : key_rd_reg;
        pay_eff = fwd_reg ? fwd_pay_reg : pay_rd_reg;
        sd = has4_reg ? key_eff.depth : 16'd0;
        expired = (sd != 16'd0) && ((now4_reg - key_eff.stamp) > timeout_reg);
        if (expired) begin
            sd = 16'd0;
        end
        pix_ok = dep4_reg != 16'd0;
        show = has4_reg && (({1'b0, dep4_reg} + {1'b0, margin_reg}) < {1'b0, sd});
        emit_pix = v4_reg && pix_ok;
        emit_sh = v4_reg && (pix_ok ? show : (sd != 16'd0));
        n4 = {1'b0, emit_pix} + {1'b0, emit_sh};
        wr_key = key_eff;
        wr_pay = pay_eff;
        wr_en = 1'b0;
        if (pix_ok && !show && has4_reg) begin
            wr_en = v4_reg;
            wr_key.depth = dep4_reg;
            wr_key.stamp = now4_reg;
            wr_pay.x = px;
            wr_pay.y = py;
            wr_pay.color = {1'b0, pc4_reg[23:17], 1'b0, pc4_reg[15:9], 1'b0, pc4_reg[7:1]};
        end else if (expired) begin
            wr_en = v4_reg;
            wr_key.depth = 16'd0;
        end
    end

    // Output buffer: two points.
    point_t      ob0_reg, ob1_reg;
    point_t      pt_pix, pt_sh;

    always_comb begin
        pt_pix.x = px; pt_pix.y = py; pt_pix.z = dep4_reg; pt_pix.color = pc4_reg;
        pt_pix.from_shadow = 1'b0; pt_pix.last = !show;
        pt_sh.x = pay_eff.x; pt_sh.y = pay_eff.y; pt_sh.z = sd;
        pt_sh.color = pay_eff.color; pt_sh.from_shadow = 1'b1; pt_sh.last = 1'b1;
    end

    assign out_take = m_tvalid && m_tready;
    // Stage 4 moves on only when the buffer has room for all its points.
    always_comb begin
        room = 2'd2 - ocnt_reg + {1'b0, out_take};
        adv = !clr_reg && (n4 <= room);
    end
    assign s_tready = adv;
    assign s_take = s_tvalid && adv;

    assign m_tvalid = ocnt_reg != 2'd0;
    assign m_tdata = {ob0_reg.color, ob0_reg.z, ob0_reg.y, ob0_reg.x};
    assign m_tuser = ob0_reg.from_shadow;
    assign m_tlast = ob0_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= 1'b1; clr_cnt_reg <= '0;
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
            col_reg <= '0; row_reg <= '0;
            fwd_reg <= 1'b0;
            ocnt_reg <= '0;
        end else begin
            if (clr_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IdxW'(MaxPixels - 1)) clr_reg <= 1'b0;
            end
            if (adv) begin
                v1_reg <= s_take; v2_reg <= v1_reg; v3_reg <= v2_reg; v4_reg <= v3_reg;
                if (s_take) begin
                    col_reg <= col_nx; row_reg <= row_nx;
                end
                fwd_reg <= wr_en && (idx3_reg == idx4_reg);
            end
            case ({out_take, adv && n4 != 2'd0})
                2'b10: ocnt_reg <= ocnt_reg - 1'b1;
                2'b01: ocnt_reg <= ocnt_reg + n4;
                2'b11: ocnt_reg <= ocnt_reg + n4 - 1'b1;
                default: ;
            endcase
        end
    end

    // Point buffer shifting.
    always_ff @(posedge aclk) begin
        point_t q0, q1, first, sec;
        logic [1:0] c;
        q0 = ob0_reg; q1 = ob1_reg; c = ocnt_reg;
        if (out_take) begin q0 = q1; c = c - 1'b1; end
        first = emit_pix ? pt_pix : pt_sh;
        sec = pt_sh;
        if (adv && n4 != 2'd0) begin
            if (c == 2'd0) begin
                q0 = first;
                if (n4 == 2'd2) q1 = sec;
            end else begin
                q1 = first;
            end
        end
        ob0_reg <= q0; ob1_reg <= q1;
    end

    // Pipeline payload.
    always_ff @(posedge aclk) begin
        if (adv) begin
            col1_reg <= col_cur; row1_reg <= row_cur;
            idx1_reg <= idx_full[IdxW-1:0];
            has1_reg <= idx_full < 21'(MaxPixels);
            dep1_reg <= s_tdata[15:0];
            pc1_reg <= s_tdata[40] ? s_tdata[39:16] : 24'hFFFFFF;
            now1_reg <= s_tdata[72:41];
            idx2_reg <= idx1_reg; has2_reg <= has1_reg; dep2_reg <= dep1_reg;
            pc2_reg <= pc1_reg; now2_reg <= now1_reg;
            idx3_reg <= idx2_reg; has3_reg <= has2_reg; dep3_reg <= dep2_reg;
            pc3_reg <= pc2_reg; now3_reg <= now2_reg;
            idx4_reg <= idx3_reg; has4_reg <= has3_reg; dep4_reg <= dep3_reg;
            pc4_reg <= pc3_reg; now4_reg <= now3_reg;
            fwd_key_reg <= wr_key;
            fwd_pay_reg <= wr_pay;
        end
    end

    // Key memory: read at stage 3, written as stage 4 leaves, cleared after reset.
    always_ff @(posedge aclk) begin
        if (clr_reg) begin
            key_mem[clr_cnt_reg] <= '0;
        end else if (adv && wr_en) begin
            key_mem[idx4_reg] <= wr_key;
        end
        if (adv) key_rd_reg <= key_mem[idx3_reg];
    end

    // Payload memory: same timing as the key memory.
    always_ff @(posedge aclk) begin
        if (adv && wr_en) begin
            pay_mem[idx4_reg] <= wr_pay;
        end
        if (adv) pay_rd_reg <= pay_mem[idx3_reg];
    end
endmodule

[tb/testbench.sv]
module testbench;
    import dslpg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 1600000;
    localparam int TailCycles = 20;

    typedef struct {
        bit [15:0] depth;
        bit [23:0] color;
        bit        has_color;
        bit [31:0] tick;
        bit        frame_start;
    } pixel_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    depth_shadow_layer_point_gen u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    // Mirror of the block's registers and shadow store.
    bit [10:0] cfg_width = 11'd640;
    bit [10:0] cfg_height = 11'd480;
    bit [15:0] cfg_cx = 16'd5120;
    bit [15:0] cfg_cy = 16'd3840;
    bit [23:0] cfg_ifx = 24'd33554;
    bit [23:0] cfg_ify = 24'd33554;
    bit [15:0] cfg_margin = 16'd100;
    bit [31:0] cfg_timeout = 32'd30000;

    bit [15:0] store_depth[int];
    bit [31:0] store_stamp[int];
    bit [23:0] store_x[int];
    bit [23:0] store_y[int];
    bit [23:0] store_color[int];
    int unsigned column = 0;
    int unsigned row = 0;

    point_t    expected_points[$];
    int        error_count = 0;
    int        burst_left = 0;
    bit        gaps_enabled = 1'b1;
    bit [31:0] tick_now = 32'd1000;

    function automatic bit [23:0] project(int unsigned pos, bit [15:0] ctr, bit [23:0] inv,
                                          bit [15:0] depth);
        longint           offset;
        longint unsigned  mag;
        longint unsigned  r;
        offset = longint'(pos) * 16 - longint'($signed(ctr));
        mag = (offset < 0) ? longint'(-offset) : longint'(offset);
        r = (mag * inv * depth + (64'd1 << 23)) >> 24;
        if (offset < 0) begin
            if (r > 64'd8388608) r = 64'd8388608;
            return 24'(-r);
        end
        if (r > 64'd8388607) r = 64'd8388607;
        return r[23:0];
    endfunction

    function automatic point_t make_point(bit [23:0] x, bit [23:0] y, bit [15:0] z,
                                          bit [23:0] color, bit shadow, bit last);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.color = color;
        p.from_shadow = shadow;
        p.last = last;
        return p;
    endfunction

    task automatic expect_point(point_t p);
        expected_points = {expected_points, p};
    endtask

    task automatic predict_points(pixel_t px);
        bit [23:0] color;
        int        idx;
        bit        in_store;
        bit [15:0] sd;
        bit [23:0] x;
        bit [23:0] y;
        bit        show;
        color = px.has_color ? px.color : 24'hFFFFFF;
        if (px.frame_start) begin
            column = 0;
            row = 0;
        end
        idx = int'(row * cfg_width + column);
        in_store = idx < MaxPixels;
        sd = 0;
        if (in_store && store_depth.exists(idx)) begin
            sd = store_depth[idx];
            if (sd != 0 && (px.tick - store_stamp[idx]) > cfg_timeout) begin
                store_depth[idx] = 0;
                sd = 0;
            end
        end
        if (px.depth != 0) begin
            x = project(column, cfg_cx, cfg_ifx, px.depth);
            y = project(row, cfg_cy, cfg_ify, px.depth);
            show = in_store && (32'(px.depth) + 32'(cfg_margin) < 32'(sd));
            expect_point(make_point(x, y, px.depth, color, 1'b0, !show));
            if (show) begin
                expect_point(make_point(store_x[idx], store_y[idx], sd,
                                        store_color[idx], 1'b1, 1'b1));
            end else if (in_store) begin
                store_x[idx] = x;
                store_y[idx] = y;
                store_color[idx] = (color >> 1) & 24'h7F7F7F;
                store_depth[idx] = px.depth;
                store_stamp[idx] = px.tick;
            end
        end else if (in_store && sd != 0) begin
            expect_point(make_point(store_x[idx], store_y[idx], sd,
                                    store_color[idx], 1'b1, 1'b1));
        end
        if (column + 1 >= cfg_width || column >= CounterMax) begin
            column = 0;
            if (row + 1 >= cfg_height || row >= CounterMax) row = 0;
            else row++;
        end else begin
            column++;
        end
    endtask

    task automatic send_pixel(pixel_t px);
        logic [79:0] packed_item;
        if (gaps_enabled && burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left > 0) burst_left--;
        packed_item = {7'd0, px.tick, px.has_color, px.color, px.depth};
        s_tdata <= packed_item;
        s_tuser <= px.frame_start;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_points(px);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [4:0] addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            RegWidth:   cfg_width = value[10:0];
            RegHeight:  cfg_height = value[10:0];
            RegCenterX: cfg_cx = value[15:0];
            RegCenterY: cfg_cy = value[15:0];
            RegInvFx:   cfg_ifx = value[23:0];
            RegInvFy:   cfg_ify = value[23:0];
            RegMargin:  cfg_margin = value[15:0];
            RegTimeout: cfg_timeout = value;
            default: ;
        endcase
    endtask

    task automatic configure(int w, int h, int cx, int cy, int ifx, int ify, int margin,
                             int unsigned timeout);
        write_reg(RegWidth, 32'(w));
        write_reg(RegHeight, 32'(h));
        write_reg(RegCenterX, 32'(cx));
        write_reg(RegCenterY, 32'(cy));
        write_reg(RegInvFx, 32'(ifx));
        write_reg(RegInvFy, 32'(ify));
        write_reg(RegMargin, 32'(margin));
        write_reg(RegTimeout, 32'(timeout));
    endtask

    function automatic pixel_t pixel(bit [15:0] depth, bit [31:0] tick, bit fs);
        pixel_t px;
        px.depth = depth;
        px.color = 24'($urandom_range(0, 'hFFFFFF));
        px.has_color = 1'($urandom_range(0, 1));
        px.tick = tick;
        px.frame_start = fs;
        return px;
    endfunction

    function automatic bit [15:0] random_depth();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 15) return 16'd0;
        if (sel < 20) return 16'($urandom_range(1, 65535));
        if (sel < 23) return 16'hFFFF;
        if (sel < 26) return 16'd1;
        return 16'($urandom_range(300, 4000));
    endfunction

    task automatic test_reset_defaults();
        for (int i = 0; i < 4; i++) send_pixel(pixel(random_depth() | 16'd1, 32'd50, i == 0));
        send_pixel(pixel(16'hFFFF, 32'd50, 1'b0));
        wait_idle();
    endtask

    task automatic test_directed_cases();
        bit [15:0] frame_a[4] = '{16'd1000, 16'd0, 16'hFFFF, 16'd1};
        bit [15:0] frame_b[4] = '{16'd500, 16'd0, 16'hFFFF, 16'd0};
        configure(4, 2, -32768, 32767, 'hFFFFFF, 0, 100, 1000);
        for (int i = 0; i < 4; i++) send_pixel(pixel(frame_a[i], 32'd100, i == 0));
        for (int i = 0; i < 4; i++) send_pixel(pixel(frame_b[i], 32'd600, i == 0));
        // Shadows go stale once the tick moves past the timeout, with wrap-around.
        for (int i = 0; i < 4; i++) send_pixel(pixel(16'd0, 32'd2000, i == 0));
        for (int i = 0; i < 4; i++) send_pixel(pixel(16'd40, 32'hFFFFFF00, i == 0));
        for (int i = 0; i < 4; i++) send_pixel(pixel(16'd0, 32'd100, i == 0));
        wait_idle();
    endtask

    task automatic test_random_frames();
        int w;
        int h;
        int n;
        int pos;
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: configure(8, 4, 5120, 3840, 33554, 33554, 100, 30000);
                1: configure(1, 1, 32767, -32768, 'hFFFFFF, 'hFFFFFF, 0, 0);
                2: configure(1024, 2, -32768, 32767, 'hFFFFFF, 'hFFFFFF, 65535,
                             32'hFFFFFFFF);
                3: configure(3, 1024, $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 'hFFFFFF), $urandom_range(0, 'hFFFFFF),
                             $urandom_range(0, 300), $urandom_range(0, 4000));
                4: configure(16, 8, 128, 64, 1 << 20, 1 << 20, 50, 500);
                5: configure(5, 3, $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 'hFFFFFF), 0, $urandom_range(0, 65535),
                             $urandom);
                default: configure(7, 5, 40, 40, 33554, 33554, 10, 200);
            endcase
            w = cfg_width;
            h = cfg_height;
            n = 0;
            pos = 0;
            while (n < 250) begin
                if (pos == 0 || $urandom_range(0, 60) == 0) begin
                    tick_now += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300);
                end
                send_pixel(pixel(random_depth(), tick_now,
                                 pos == 0 || $urandom_range(0, 80) == 0));
                pos = (pos + 1) % ((w > 32 ? 32 : w) * (h > 4 ? 4 : h));
                n++;
                if (n == 120 && phase == 0) wait_idle();
            end
            wait_idle();
        end
    endtask

    task automatic test_wide_image();
        configure(2047, 1024, 0, 0, 'h100000, 'h100000, 0, 32'hFFFFFFFF);
        send_pixel(pixel(16'd0, 32'd5, 1'b1));
        for (int i = 0; i < 20; i++) send_pixel(pixel(random_depth(), 32'd5, 1'b0));
        for (int i = 0; i < 5; i++) send_pixel(pixel(16'd0, 32'd5, 1'b0));
        wait_idle();
    endtask

    always @(posedge aclk) begin
        int mode;
        mode = int'(($time / 20000) % 3);
        if (mode == 0) m_tready <= 1'b1;
        else if (mode == 1) m_tready <= ($urandom_range(0, 9) < 6);
        else m_tready <= (($time / 10) % 7) < 4;
    end

    always @(posedge aclk) begin
        point_t want;
        point_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = make_point(m_tdata[23:0], m_tdata[47:24], m_tdata[63:48], m_tdata[87:64],
                             m_tuser, m_tlast);
            if (expected_points.size() == 0) begin
                $error("unexpected point x=%h y=%h z=%h", got.x, got.y, got.z);
                error_count++;
            end else begin
                want = expected_points.pop_front();
                if (got.x != want.x) begin
                    $error("point_x expected %h actual %h", want.x, got.x);
                    error_count++;
                end
                if (got.y != want.y) begin
                    $error("point_y expected %h actual %h", want.y, got.y);
                    error_count++;
                end
                if (got.z != want.z) begin
                    $error("point_z expected %h actual %h", want.z, got.z);
                    error_count++;
                end
                if (got.color != want.color) begin
                    $error("point_color expected %h actual %h", want.color, got.color);
                    error_count++;
                end
                if (got.from_shadow != want.from_shadow) begin
                    $error("from_shadow expected %b actual %b", want.from_shadow,
                           got.from_shadow);
                    error_count++;
                end
                if (got.last != want.last) begin
                    $error("last expected %b actual %b", want.last, got.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
        else quiet++;
        if (quiet >= WatchdogLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_cases();
        test_random_frames();
        test_wide_image();
        wait_idle();
        repeat (TailCycles) @(posedge aclk);
        if (error_count == 0 && expected_points.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[depth_shadow_layer_point_gen.f]
src/dslpg_pkg.sv
src/dslpg_project.sv
src/depth_shadow_layer_point_gen.sv
tb/testbench.sv
